// File: hdl/mfmtd_pkg.sv
`default_nettype none

package mfmtd_pkg;

  // field widths fixed by the frame layout
  localparam int unsigned IdxW     = 3;
  localparam int unsigned AngleW   = 13;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned CurrentW = 16;
  localparam int unsigned TempW    = 8;
  localparam int unsigned TotalW   = 32;
  localparam int unsigned MaskW    = 6;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned DeltaW   = AngleW + 2;

  localparam int unsigned MotorCount = 6;
  localparam int unsigned MotorAw    = (MotorCount > 1) ? $clog2(MotorCount) : 1;
  localparam int unsigned EncSpan    = 8192;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgInvertMask    = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgGroupModeMask = 1'b1;

  localparam logic [MaskW-1:0] InvertMaskRst    = 6'd5;
  localparam logic [MaskW-1:0] GroupModeMaskRst = 6'd15;

  // per-motor tracking entry kept in the state ram
  typedef struct packed {
    logic [AngleW-1:0] prev_angle;
    logic [TotalW-1:0] total;
  } track_t;

  // shorter of the direct and the wrapped step, direct on a tie
  function automatic logic signed [DeltaW-1:0] pick_delta(
    input logic [AngleW-1:0] now_a,
    input logic [AngleW-1:0] last_a
  );
    logic signed [DeltaW-1:0] direct;
    logic signed [DeltaW-1:0] wrapped;
    logic signed [DeltaW-1:0] span;
    logic signed [DeltaW-1:0] mag_d;
    logic signed [DeltaW-1:0] mag_w;
    span    = $signed(DeltaW'(EncSpan));
    direct  = $signed({2'b00, now_a}) - $signed({2'b00, last_a});
    wrapped = (now_a < last_a) ? (direct + span) : (direct - span);
    mag_d   = (direct < 0) ? -direct : direct;
    mag_w   = (wrapped < 0) ? -wrapped : wrapped;
    return (mag_w < mag_d) ? wrapped : direct;
  endfunction

endpackage

`default_nettype wire

// File: hdl/mfmtd_if.sv
`default_nettype none

interface mfmtd_frame_if;
  logic                                  valid;
  logic                                  ready;
  logic [mfmtd_pkg::IdxW-1:0]            motor_index;
  logic [mfmtd_pkg::AngleW-1:0]          enc_angle;
  logic signed [mfmtd_pkg::SpeedW-1:0]   rotor_speed;
  logic signed [mfmtd_pkg::CurrentW-1:0] given_current;
  logic [mfmtd_pkg::TempW-1:0]           raw_temperature;

  modport source (output valid, motor_index, enc_angle, rotor_speed, given_current,
                  raw_temperature, input ready);
  modport sink (input valid, motor_index, enc_angle, rotor_speed, given_current,
                raw_temperature, output ready);
endinterface

interface mfmtd_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [mfmtd_pkg::IdxW-1:0]            motor_out;
  logic [mfmtd_pkg::AngleW-1:0]          logical_angle;
  logic signed [mfmtd_pkg::SpeedW-1:0]   logical_speed;
  logic signed [mfmtd_pkg::CurrentW-1:0] logical_current;
  logic [mfmtd_pkg::TempW-1:0]           temperature;
  logic signed [mfmtd_pkg::TotalW-1:0]   multi_turn_angle;
  logic                                  first_frame;
  logic                                  online;

  modport source (output valid, motor_out, logical_angle, logical_speed,
                  logical_current, temperature, multi_turn_angle, first_frame,
                  online, input ready);
  modport sink (input valid, motor_out, logical_angle, logical_speed,
                logical_current, temperature, multi_turn_angle, first_frame,
                online, output ready);
endinterface

`default_nettype wire

// File: hdl/motor_feedback_multiturn_decoder.sv
`default_nettype none

// channel   dir  port      payload
// --------  ---  --------  ------------------------------------------------
// frame     in   frame_i   motor_index, raw angle/speed/current/temperature
// result    out  result_o  corrected fields, multi_turn_angle, flags
// config    in   cfg_*_i   invert_mask (0), group_mode_mask (1)
//
// two-stage pipeline, middle stage and result register: a word is taken
// each cycle unless stalled; the registered state ram read sets the depth
// reset clears the masks to their defaults and all seen/online flags; no
// clearing pass, since an unseen motor never uses its ram entry
// a stalled result register holds the middle stage, which in turn stops
// the input; a word whose motor index is out of range is taken and dropped
module motor_feedback_multiturn_decoder (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [mfmtd_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [mfmtd_pkg::MaskW-1:0]     cfg_data_i,
  mfmtd_frame_if.sink                          frame_i,
  mfmtd_result_if.source                       result_o
);

  // configuration masks
  logic [mfmtd_pkg::MaskW-1:0] invert_q, group_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= mfmtd_pkg::InvertMaskRst;
      group_q  <= mfmtd_pkg::GroupModeMaskRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mfmtd_pkg::CfgInvertMask:    invert_q <= cfg_data_i;
        mfmtd_pkg::CfgGroupModeMask: group_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- input stage: mirror and ram read ----------------
  logic                                s1_valid_q, s1_valid_d;
  logic                                s1_adv;
  logic                                in_ok;
  logic                                in_acc;
  logic                                s1_load;
  logic                                mirror;
  logic [mfmtd_pkg::AngleW-1:0]        in_angle;
  logic [mfmtd_pkg::SpeedW-1:0]        in_speed;
  logic [mfmtd_pkg::CurrentW-1:0]      in_current;

  assign in_ok   = (32'(frame_i.motor_index) < mfmtd_pkg::MotorCount);
  assign frame_i.ready = !s1_valid_q || s1_adv;
  assign in_acc  = frame_i.valid && frame_i.ready;
  assign s1_load = in_acc && in_ok;

  always_comb begin
    mirror = 1'b0;
    if ((32'(frame_i.motor_index) < mfmtd_pkg::MaskW) && in_ok) begin
      mirror = invert_q[frame_i.motor_index] && group_q[frame_i.motor_index];
    end
    // span minus angle modulo the span, which leaves a zero angle at zero
    in_angle   = mirror ? (mfmtd_pkg::AngleW'(0) - frame_i.enc_angle) : frame_i.enc_angle;
    in_speed   = mirror ? (mfmtd_pkg::SpeedW'(0) - frame_i.rotor_speed) : frame_i.rotor_speed;
    in_current = mirror ? (mfmtd_pkg::CurrentW'(0) - frame_i.given_current)
                        : frame_i.given_current;
  end

  // middle stage payload
  logic [mfmtd_pkg::IdxW-1:0]     s1_idx_q;
  logic [mfmtd_pkg::AngleW-1:0]   s1_angle_q;
  logic [mfmtd_pkg::SpeedW-1:0]   s1_speed_q;
  logic [mfmtd_pkg::CurrentW-1:0] s1_current_q;
  logic [mfmtd_pkg::TempW-1:0]    s1_temp_q;
  logic                           s1_fwd_q;

  assign s1_valid_d = s1_load ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  // the ram write of the leaving word lands on the same edge as the read of
  // the arriving one, so a match there takes the written entry instead
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_idx_q     <= frame_i.motor_index;
      s1_angle_q   <= in_angle;
      s1_speed_q   <= in_speed;
      s1_current_q <= in_current;
      s1_temp_q    <= frame_i.raw_temperature;
      s1_fwd_q     <= s1_adv && (frame_i.motor_index == s1_idx_q);
    end
  end

  // ---------------- state ram ----------------
  mfmtd_pkg::track_t rd_entry, wr_entry, wr_entry_q, old_entry;

  mfmtd_ram #(
    .Width ($bits(mfmtd_pkg::track_t)),
    .Depth (mfmtd_pkg::MotorCount)
  ) u_track_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_idx_q[mfmtd_pkg::MotorAw-1:0]),
    .wdata_i (wr_entry),
    .re_i    (s1_load),
    .raddr_i (frame_i.motor_index[mfmtd_pkg::MotorAw-1:0]),
    .rdata_o (rd_entry)
  );

  // seen and online flags live in flops so reset clears them at once
  logic [mfmtd_pkg::MotorCount-1:0] seen_q, online_q;

  // ---------------- middle stage: unwrap and accumulate ----------------
  logic                              seen;
  logic                              online_new;
  logic signed [mfmtd_pkg::DeltaW-1:0] delta;
  logic [mfmtd_pkg::TotalW-1:0]      total_new;

  always_comb begin
    old_entry  = s1_fwd_q ? wr_entry_q : rd_entry;
    seen       = seen_q[s1_idx_q[mfmtd_pkg::MotorAw-1:0]];
    delta      = mfmtd_pkg::pick_delta(s1_angle_q, old_entry.prev_angle);
    // first word of a motor starts the total at zero and keeps its online flag
    total_new  = seen ? (old_entry.total + mfmtd_pkg::TotalW'(delta))
                      : '0;
    online_new = seen ? 1'b1 : online_q[s1_idx_q[mfmtd_pkg::MotorAw-1:0]];
    wr_entry.prev_angle = s1_angle_q;
    wr_entry.total      = total_new;
  end

  logic out_valid_q, out_valid_d;

  assign s1_adv      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign out_valid_d = s1_adv ? 1'b1 : (result_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      online_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        seen_q[s1_idx_q[mfmtd_pkg::MotorAw-1:0]]   <= 1'b1;
        online_q[s1_idx_q[mfmtd_pkg::MotorAw-1:0]] <= online_new;
      end
    end
  end

  // ---------------- result register ----------------
  logic [mfmtd_pkg::IdxW-1:0]     out_idx_q;
  logic [mfmtd_pkg::AngleW-1:0]   out_angle_q;
  logic [mfmtd_pkg::SpeedW-1:0]   out_speed_q;
  logic [mfmtd_pkg::CurrentW-1:0] out_current_q;
  logic [mfmtd_pkg::TempW-1:0]    out_temp_q;
  logic [mfmtd_pkg::TotalW-1:0]   out_total_q;
  logic                           out_first_q;
  logic                           out_online_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      wr_entry_q    <= wr_entry;
      out_idx_q     <= s1_idx_q;
      out_angle_q   <= s1_angle_q;
      out_speed_q   <= s1_speed_q;
      out_current_q <= s1_current_q;
      out_temp_q    <= s1_temp_q;
      out_total_q   <= total_new;
      out_first_q   <= !seen;
      out_online_q  <= online_new;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.motor_out        = out_idx_q;
  assign result_o.logical_angle    = out_angle_q;
  assign result_o.logical_speed    = $signed(out_speed_q);
  assign result_o.logical_current  = $signed(out_current_q);
  assign result_o.temperature      = out_temp_q;
  assign result_o.multi_turn_angle = $signed(out_total_q);
  assign result_o.first_frame      = out_first_q;
  assign result_o.online           = out_online_q;

endmodule

`default_nettype wire

// File: hdl/mfmtd_ram.sv
`default_nettype none

module mfmtd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                              rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: dv/multiturn_checker.sv
module multiturn_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mfmtd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [mfmtd_pkg::MaskW-1:0]   cfg_data_i,
  mfmtd_frame_if                        frame_i,
  mfmtd_result_if                       result_i,
  output int unsigned                   outstanding_o,
  output int unsigned                   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mfmtd_pkg::*;

  typedef struct packed {
    logic [IdxW-1:0]     motor_out;
    logic [AngleW-1:0]   logical_angle;
    logic [SpeedW-1:0]   logical_speed;
    logic [CurrentW-1:0] logical_current;
    logic [TempW-1:0]    temperature;
    logic [TotalW-1:0]   multi_turn_angle;
    logic                first_frame;
    logic                online;
  } decoded_t;

  // own copy of the masks and the per-motor tracking
  logic [MaskW-1:0]  invert_mask;
  logic [MaskW-1:0]  group_mask;
  logic              seen_q   [MotorCount];
  logic [AngleW-1:0] last_q   [MotorCount];
  logic [TotalW-1:0] total_q  [MotorCount];
  logic              online_q [MotorCount];

  decoded_t    pending_decodes [$];
  decoded_t    want;

  function automatic decoded_t decode_frame(
    input logic [IdxW-1:0]     idx,
    input logic [AngleW-1:0]   angle,
    input logic [SpeedW-1:0]   speed,
    input logic [CurrentW-1:0] current,
    input logic [TempW-1:0]    temp
  );
    decoded_t          d;
    logic [AngleW-1:0] ang;
    logic [SpeedW-1:0] spd;
    logic [CurrentW-1:0] cur;
    int                span;
    int                direct;
    int                wrapped;
    int                step;
    span = EncSpan;
    ang  = angle;
    spd  = speed;
    cur  = current;
    if (invert_mask[idx] && group_mask[idx]) begin
      if (ang != '0) ang = AngleW'(span - int'(ang));
      spd = -spd;
      cur = -cur;
    end
    d.first_frame = 1'b0;
    if (!seen_q[idx]) begin
      seen_q[idx]    = 1'b1;
      total_q[idx]   = '0;
      d.first_frame  = 1'b1;
    end else begin
      direct  = int'(ang) - int'(last_q[idx]);
      wrapped = (ang < last_q[idx]) ? direct + span : direct - span;
      step    = ((wrapped < 0 ? -wrapped : wrapped) < (direct < 0 ? -direct : direct))
                ? wrapped : direct;
      total_q[idx]  = total_q[idx] + TotalW'(step);
      online_q[idx] = 1'b1;
    end
    last_q[idx]        = ang;
    d.motor_out        = idx;
    d.logical_angle    = ang;
    d.logical_speed    = spd;
    d.logical_current  = cur;
    d.temperature      = temp;
    d.multi_turn_angle = total_q[idx];
    d.online           = online_q[idx];
    return d;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] expv,
                             input logic signed [63:0] actv);
    if (actv !== expv) begin
      fail_count_o = fail_count_o + 1;
      $error("%s: expected %0d, got %0d", name, expv, actv);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_mask = InvertMaskRst;
      group_mask  = GroupModeMaskRst;
      for (int m = 0; m < MotorCount; m++) begin
        seen_q[m]   = 1'b0;
        last_q[m]   = '0;
        total_q[m]  = '0;
        online_q[m] = 1'b0;
      end
      pending_decodes.delete();
      fail_count_o  = 0;
      outstanding_o <= 0;
    end else begin
      if (frame_i.valid && frame_i.ready && frame_i.motor_index < MotorCount) begin
        pending_decodes.push_back(decode_frame(frame_i.motor_index, frame_i.enc_angle,
                                               frame_i.rotor_speed, frame_i.given_current,
                                               frame_i.raw_temperature));
      end
      if (result_i.valid && result_i.ready) begin
        if (pending_decodes.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $error("result word with no frame waiting for it");
        end else begin
          want = pending_decodes.pop_front();
          check_field("motor_out", want.motor_out, result_i.motor_out);
          check_field("logical_angle", want.logical_angle, result_i.logical_angle);
          check_field("logical_speed", $signed(want.logical_speed),
                      result_i.logical_speed);
          check_field("logical_current", $signed(want.logical_current),
                      result_i.logical_current);
          check_field("temperature", want.temperature, result_i.temperature);
          check_field("multi_turn_angle", $signed(want.multi_turn_angle),
                      result_i.multi_turn_angle);
          check_field("first_frame", want.first_frame, result_i.first_frame);
          check_field("online", want.online, result_i.online);
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgInvertMask) invert_mask = cfg_data_i;
        else group_mask = cfg_data_i;
      end
      outstanding_o <= pending_decodes.size();
    end
  end

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mfmtd_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [MaskW-1:0]    cfg_data_i;
  int unsigned         outstanding;
  int unsigned         fail_count;

  // random stalls on both sides while set; cleared for the closing soak
  bit                  idling_on = 1'b1;

  // last raw angle sent per motor index, so random steps can walk from it
  logic [AngleW-1:0]   last_raw [8];

  mfmtd_frame_if  frame_ch ();
  mfmtd_result_if result_ch ();

  motor_feedback_multiturn_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .frame_i    (frame_ch),
    .result_o   (result_ch)
  );

  multiturn_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .frame_i       (frame_ch),
    .result_i      (result_ch),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // result side: bursts of back-pressure between runs of ready
  initial begin
    int unsigned hold;
    hold = 0;
    result_ch.ready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!idling_on) begin
        result_ch.ready <= 1'b1;
        hold = 0;
      end else if (hold != 0) begin
        hold = hold - 1;
      end else if ($urandom_range(0, 2) == 0) begin
        result_ch.ready <= 1'b0;
        hold = $urandom_range(0, 13);
      end else begin
        result_ch.ready <= 1'b1;
        hold = $urandom_range(0, 30);
      end
    end
  end

  // offer one word and hold it until taken, then maybe leave a gap
  task automatic push_frame(input logic [IdxW-1:0] m, input logic [AngleW-1:0] a,
                            input logic [SpeedW-1:0] s, input logic [CurrentW-1:0] c,
                            input logic [TempW-1:0] t);
    frame_ch.valid           <= 1'b1;
    frame_ch.motor_index     <= m;
    frame_ch.enc_angle       <= a;
    frame_ch.rotor_speed     <= s;
    frame_ch.given_current   <= c;
    frame_ch.raw_temperature <= t;
    last_raw[m] = a;
    do @(posedge clk_i); while (frame_ch.ready !== 1'b1);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  // speed and current favour the corners, where negation wraps
  function automatic logic [15:0] pick_signed16();
    case ($urandom_range(0, 9))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // mostly plausible rotor motion from the last angle, some jumps and
  // some words for motors that do not exist
  task automatic push_random(output bit counted);
    logic [IdxW-1:0]   m;
    logic [AngleW-1:0] a;
    int unsigned       sel;
    int                step;
    if ($urandom_range(0, 99) < 6) m = IdxW'($urandom_range(MotorCount, 7));
    else m = IdxW'($urandom_range(0, MotorCount - 1));
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      step = int'($urandom_range(0, 200)) - 100;
      a    = last_raw[m] + AngleW'(step);
    end else if (sel < 55) begin
      // half a turn away: direct and wrapped steps tie
      a = last_raw[m] + AngleW'(4096);
    end else if (sel < 65) begin
      a = last_raw[m] + ($urandom_range(0, 1) ? AngleW'(4095) : AngleW'(4097));
    end else if (sel < 75) begin
      a = $urandom_range(0, 1) ? '0 : '1;
    end else begin
      a = AngleW'($urandom);
    end
    counted = (m < MotorCount);
    push_frame(m, a, pick_signed16(), pick_signed16(), TempW'($urandom));
  endtask

  // drain, let a dropped word clear the pipe, then load both masks
  task automatic program_masks(input logic [MaskW-1:0] inv, input logic [MaskW-1:0] grp);
    frame_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgInvertMask;
    cfg_data_i <= inv;
    @(posedge clk_i);
    cfg_idx_i  <= CfgGroupModeMask;
    cfg_data_i <= grp;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin
    int unsigned       drawn;
    bit                counted;
    logic [AngleW-1:0] soak_angle;
    for (int m = 0; m < 8; m++) last_raw[m] = '0;
    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_idx_i                <= CfgInvertMask;
    cfg_data_i               <= '0;
    frame_ch.valid           <= 1'b0;
    frame_ch.motor_index     <= '0;
    frame_ch.enc_angle       <= '0;
    frame_ch.rotor_speed     <= '0;
    frame_ch.given_current   <= '0;
    frame_ch.raw_temperature <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part under the reset masks: motors 0 and 2 are mirrored
    // mirrored zero angle on a first frame, negation of the most negative
    push_frame(0, 13'd0,    16'h8000, 16'h7fff, 8'd0);
    push_frame(0, 13'd8191, 16'h7fff, 16'h8000, 8'd255);
    // mirrored 1 becomes 8191, a backward step across the wrap
    push_frame(0, 13'd1,    16'h0001, 16'hffff, 8'd17);
    push_frame(1, 13'd8191, 16'h0000, 16'hffff, 8'h55);
    push_frame(1, 13'd0,    16'h1234, 16'hedcb, 8'haa);
    // exact half turns: the direct step wins either way
    push_frame(1, 13'd4096, 16'h8000, 16'h8000, 8'd1);
    push_frame(1, 13'd0,    16'h7fff, 16'h7fff, 8'd2);
    push_frame(1, 13'd4095, 16'hffff, 16'h0000, 8'd3);
    push_frame(1, 13'd8191, 16'h0001, 16'h0001, 8'd4);
    push_frame(2, 13'd4096, 16'hff00, 16'h00ff, 8'd128);
    push_frame(2, 13'd1,    16'h8000, 16'h0000, 8'd127);
    push_frame(3, 13'd100,  16'h8000, 16'h8000, 8'd9);
    push_frame(4, 13'd8191, 16'h7fff, 16'h8000, 8'd250);
    push_frame(5, 13'd0,    16'h0000, 16'h0000, 8'haa);
    // motors past the end are dropped
    push_frame(6, 13'd1234, 16'h0101, 16'h0202, 8'd6);
    push_frame(7, 13'd8191, 16'hffff, 16'hffff, 8'd255);
    push_frame(4, 13'd0,    16'h4000, 16'hc000, 8'd0);
    push_frame(5, 13'd8191, 16'hc000, 16'h4000, 8'd255);
    push_frame(3, 13'd100,  16'h0000, 16'h8000, 8'd77);
    push_frame(2, 13'd0,    16'h7fff, 16'h8001, 8'd66);

    // random phases, each under its own pair of masks
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       program_masks(6'd0,  6'd0);
        1:       program_masks(6'd63, 6'd63);
        2:       program_masks(6'd63, 6'd0);
        3:       program_masks(6'd0,  6'd63);
        default: program_masks(MaskW'($urandom), MaskW'($urandom));
      endcase
      drawn = 0;
      while (drawn < 170) begin
        push_random(counted);
        if (counted) drawn++;
      end
    end

    // closing soak, no stalls: motor 5 turns forward at the largest step,
    // words back to back
    idling_on <= 1'b0;
    program_masks(6'd0, 6'd0);
    soak_angle = last_raw[5];
    repeat (100) begin
      soak_angle = soak_angle + AngleW'(4095);
      push_frame(5, soak_angle, 16'($urandom), 16'($urandom), TempW'($urandom));
    end
    frame_ch.valid <= 1'b0;

    do @(posedge clk_i); while (outstanding != 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("motor_feedback_multiturn_decoder: match");
    end else begin
      $display("motor_feedback_multiturn_decoder: mismatch");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin
    #40ms;
    $display("motor_feedback_multiturn_decoder: mismatch");
    $finish;
  end

endmodule
